@@ sv/rrt_pkg.sv @@
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared widths, codes, flag constants and structs for the reserved region
// translator.
// ----------------------------------------------------------------------------
`default_nettype none

package rrt_pkg;

   localparam int REGION_SLOTS_DEF = 8;

   localparam int ADDR_W     = 64;
   localparam int PAGES_W    = 32;
   localparam int FLAGS_W    = 64;
   localparam int COUNT_W    = 4;
   localparam int SLOT_W     = 3;
   localparam int RTYPE_W    = 2;
   localparam int PAGE_OFS_W = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_XLATE = 1'b1;

   // region types
   localparam logic [RTYPE_W-1:0] RTYPE_IMAGE = 2'd0;
   localparam logic [RTYPE_W-1:0] RTYPE_STACK = 2'd1;
   localparam logic [RTYPE_W-1:0] RTYPE_OTHER = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_ADDRESS = 2'd1;

   localparam logic [FLAGS_W-1:0] FLAG_PRESENT  = 64'h0000_0000_0000_0001;
   localparam logic [FLAGS_W-1:0] FLAG_WRITABLE = 64'h0000_0000_0000_0002;
   localparam logic [FLAGS_W-1:0] FLAG_USER     = 64'h0000_0000_0000_0004;
   localparam logic [FLAGS_W-1:0] FLAG_NX       = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [PAGES_W-1:0] pages;
      logic [ADDR_W-1:0]  backing;
      logic [RTYPE_W-1:0] rtype;
   } rrt_entry_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic wr_en;
      logic scan_clear;
      logic scan_step;
      logic res_hit;
      logic res_clear;
      logic out_load;
   } rrt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic kind_write;
      logic aligned;
      logic lim_zero;
      logic issue_done;
      logic match_found;
      logic busy;
   } rrt_sts_type;

   function automatic logic [FLAGS_W-1:0] page_flags_f(input logic [RTYPE_W-1:0] rtype,
                                                         input logic entry_page);
      logic [FLAGS_W-1:0] f;
      f = FLAG_PRESENT | FLAG_USER;
      case (rtype)
         RTYPE_IMAGE: begin
            if (!entry_page) begin
               f = f | FLAG_NX;
            end
         end
         RTYPE_STACK: f = f | FLAG_WRITABLE | FLAG_NX;
         default:     f = f | FLAG_NX;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

@@ sv/rrt_if.sv @@
// ----------------------------------------------------------------------------
// rrt_if
// Valid/ready channels of the reserved region translator: request, response
// and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrt_req_if
   import rrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [SLOT_W-1:0]  region_slot;
   logic [ADDR_W-1:0]  region_base;
   logic [PAGES_W-1:0] region_pages;
   logic [ADDR_W-1:0]  region_backing;
   logic [RTYPE_W-1:0] region_type;
   logic [ADDR_W-1:0]  virtual_address;

   modport source (output valid, kind, region_slot, region_base, region_pages,
                   region_backing, region_type, virtual_address, input ready);
   modport sink   (input valid, kind, region_slot, region_base, region_pages,
                   region_backing, region_type, virtual_address, output ready);
endinterface

interface rrt_rsp_if
   import rrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [ADDR_W-1:0]  physical_address;
   logic [FLAGS_W-1:0] page_flags;

   modport source (output valid, hit, physical_address, page_flags, input ready);
   modport sink   (input valid, hit, physical_address, page_flags, output ready);
endinterface

interface rrt_csr_if
   import rrt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/rrt_datapath.sv @@
// ----------------------------------------------------------------------------
// rrt_datapath
// Region table memory, request and config registers, scan pipeline
// (read, match, result) and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_datapath
   import rrt_pkg::*;
#(
   parameter int REGION_SLOTS = REGION_SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rrt_cmd_type           cmd,
   output rrt_sts_type                sts,
   input  wire logic                  req_kind,
   input  wire logic [SLOT_W-1:0]     req_region_slot,
   input  wire logic [ADDR_W-1:0]     req_region_base,
   input  wire logic [PAGES_W-1:0]    req_region_pages,
   input  wire logic [ADDR_W-1:0]     req_region_backing,
   input  wire logic [RTYPE_W-1:0]    req_region_type,
   input  wire logic [ADDR_W-1:0]     req_virtual_address,
   input  wire logic                  csr_wr,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic                       out_hit,
   output logic [ADDR_W-1:0]          out_physical_address,
   output logic [FLAGS_W-1:0]         out_page_flags
);

   localparam int IDX_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int CNT_W  = $clog2(REGION_SLOTS + 1);
   localparam int LIM_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SLW    = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

   // config registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  entry_ff, entry_in;

   // captured request
   logic               kind_ff;
   logic [SLOT_W-1:0]  slot_ff;
   rrt_entry_type      wentry_ff;
   logic [ADDR_W-1:0]  va_ff;

   // table
   rrt_entry_type           mem [REGION_SLOTS];
   logic [REGION_SLOTS-1:0] valid_ff, valid_in;
   logic [SLW-1:0]          slot_ext;
   logic [IDX_W-1:0]        wr_addr;
   logic                    slot_ok;

   // scan
   logic [LIM_W-1:0] issue_ff, issue_in;
   logic [LIM_W-1:0] lim;
   logic             issue_done;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   // read stage
   logic          s1_vld_ff, s1_vld_in;
   logic          s1_live_ff;
   rrt_entry_type s1_entry_ff;

   // match stage
   logic [ADDR_W:0]   diff;
   logic [ADDR_W:0]   end_sum;
   logic              in_range;
   logic              match;
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_match_ff;
   logic [ADDR_W-1:0] s2_diff_ff;
   logic [ADDR_W-1:0] s2_backing_ff;
   logic [RTYPE_W-1:0] s2_type_ff;

   // result and response
   logic               entry_page;
   logic               res_hit_ff;
   logic [ADDR_W-1:0]  res_phys_ff;
   logic [FLAGS_W-1:0] res_flags_ff;

   // ---------------- config ----------------
   always_comb begin
      count_in = count_ff;
      entry_in = entry_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_REGION_COUNT:  count_in = csr_data[COUNT_W-1:0];
            CSR_ENTRY_ADDRESS: entry_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         entry_ff <= '0;
      end else begin
         count_ff <= count_in;
         entry_ff <= entry_in;
      end
   end

   // ---------------- request capture ----------------
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff           <= req_kind;
         slot_ff           <= req_region_slot;
         wentry_ff.base    <= req_region_base;
         wentry_ff.pages   <= req_region_pages;
         wentry_ff.backing <= req_region_backing;
         wentry_ff.rtype   <= req_region_type;
         va_ff             <= req_virtual_address;
      end
   end

   // ---------------- table ----------------
   assign slot_ext = SLW'(slot_ff);
   assign wr_addr  = slot_ext[IDX_W-1:0];
   assign slot_ok  = slot_ext < SLW'(REGION_SLOTS);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && slot_ok) begin
         mem[wr_addr] <= wentry_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en && slot_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- scan counter ----------------
   assign lim        = (LIM_W'(count_ff) > LIM_W'(REGION_SLOTS)) ? LIM_W'(REGION_SLOTS)
                                                                 : LIM_W'(count_ff);
   assign issue_done = issue_ff >= lim;
   assign rd_en      = cmd.scan_step && !issue_done;
   assign rd_addr    = issue_ff[IDX_W-1:0];

   always_comb begin
      issue_in = issue_ff;
      if (cmd.scan_clear) begin
         issue_in = '0;
      end else if (rd_en) begin
         issue_in = issue_ff + LIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
      end else begin
         issue_ff <= issue_in;
      end
   end

   // ---------------- read stage ----------------
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_entry_ff <= mem[rd_addr];
         s1_live_ff  <= valid_ff[rd_addr];
      end
   end

   assign s1_vld_in = rd_en;

   // ---------------- match stage ----------------
   // va below base shows as a borrow; wrapped end shows as a carry
   assign diff     = {1'b0, va_ff} - {1'b0, s1_entry_ff.base};
   assign end_sum  = {1'b0, s1_entry_ff.base}
                   + {21'b0, s1_entry_ff.pages, {PAGE_OFS_W{1'b0}}};
   // offset in whole pages below page count; zero pages never matches
   assign in_range = diff[ADDR_W-1:PAGE_OFS_W] < {20'b0, s1_entry_ff.pages};
   assign match    = s1_live_ff && !diff[ADDR_W] && !end_sum[ADDR_W] && in_range
                     && (s1_entry_ff.backing != '0);

   assign s2_vld_in = s1_vld_ff && !cmd.scan_clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_match_ff   <= match;
      s2_diff_ff    <= diff[ADDR_W-1:0];
      s2_backing_ff <= s1_entry_ff.backing;
      s2_type_ff    <= s1_entry_ff.rtype;
   end

   // ---------------- result stage ----------------
   assign entry_page = (entry_ff != '0)
                       && (va_ff == {entry_ff[ADDR_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (cmd.res_hit) begin
         res_hit_ff   <= 1'b1;
         res_phys_ff  <= s2_backing_ff + s2_diff_ff;
         res_flags_ff <= page_flags_f(s2_type_ff, entry_page);
      end else if (cmd.res_clear) begin
         res_hit_ff   <= 1'b0;
         res_phys_ff  <= '0;
         res_flags_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_hit              <= res_hit_ff;
         out_physical_address <= res_phys_ff;
         out_page_flags       <= res_flags_ff;
      end
   end

   // ---------------- status ----------------
   always_comb begin
      sts.kind_write  = (kind_ff == KIND_WRITE);
      sts.aligned     = (va_ff[PAGE_OFS_W-1:0] == '0);
      sts.lim_zero    = (lim == '0);
      sts.issue_done  = issue_done;
      sts.match_found = s2_vld_ff && s2_match_ff;
      sts.busy        = s1_vld_ff || s2_vld_ff;
   end

endmodule

`default_nettype wire

@@ sv/rrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrt_ctrl
// Sequencer: takes a request, decodes it, writes a slot or runs the slot scan, and
// hands the result to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_ctrl
   import rrt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rrt_cmd_type      cmd,
   input  wire rrt_sts_type sts
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.kind_write) begin
               cmd.wr_en     = 1'b1;
               cmd.res_clear = 1'b1;
               state_in      = ST_FINISH;
            end else if (!sts.aligned || sts.lim_zero) begin
               cmd.res_clear = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.scan_clear = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = !sts.issue_done;
            // first match in slot order wins; later reads in flight drop out
            if (sts.match_found) begin
               cmd.res_hit = 1'b1;
               state_in    = ST_FINISH;
            end else if (sts.issue_done && !sts.busy) begin
               cmd.res_clear = 1'b1;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register frees up
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

@@ sv/reserved_region_translator.sv @@
// Throughput: one item at a time; the next beat is taken as soon as the scan
// sequencer is back in idle, even while the previous response waits.
// Reset (synchronous) empties the table and clears both config registers.
// ----------------------------------------------------------------------------
// reserved_region_translator
// Region table with priority lookup of page-aligned virtual addresses,
// returning the backing physical address and x86-64 style page flags.
// ----------------------------------------------------------------------------
`default_nettype none

module reserved_region_translator
   import rrt_pkg::*;
#(
   parameter int REGION_SLOTS = REGION_SLOTS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   rrt_req_if.sink   req_ch,
   rrt_rsp_if.source rsp_ch,
   rrt_csr_if.sink   csr_ch
);

   rrt_cmd_type cmd;
   rrt_sts_type sts;

   assign csr_ch.ready = 1'b1;

   rrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rrt_datapath #(
      .REGION_SLOTS (REGION_SLOTS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_kind             (req_ch.kind),
      .req_region_slot      (req_ch.region_slot),
      .req_region_base      (req_ch.region_base),
      .req_region_pages     (req_ch.region_pages),
      .req_region_backing   (req_ch.region_backing),
      .req_region_type      (req_ch.region_type),
      .req_virtual_address  (req_ch.virtual_address),
      .csr_wr               (csr_ch.valid && csr_ch.ready),
      .csr_index            (csr_ch.index),
      .csr_data             (csr_ch.data),
      .out_hit              (rsp_ch.hit),
      .out_physical_address (rsp_ch.physical_address),
      .out_page_flags       (rsp_ch.page_flags)
   );

endmodule

`default_nettype wire

@@ sv/rrt_checker.sv @@
// ----------------------------------------------------------------------------
// rrt_checker
// Port-level checks for the reserved region translator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rrt_checker
   import rrt_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_hit,
   input wire logic [ADDR_W-1:0]  rsp_physical_address,
   input wire logic [FLAGS_W-1:0] rsp_page_flags
);

   // one item in the sequencer at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_physical_address == '0) && (rsp_page_flags == '0))
      else $error("miss beat carries nonzero payload");

   // every hit is present and user; writable only together with no-execute
   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_page_flags[0] && rsp_page_flags[2]
                               && (!rsp_page_flags[1] || rsp_page_flags[63]))
      else $error("hit beat has inconsistent page flags");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_physical_address)
                                  && $stable(rsp_page_flags))
      else $error("response payload changed while stalled");

endmodule

bind reserved_region_translator rrt_checker u_rrt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_hit              (rsp_ch.hit),
   .rsp_physical_address (rsp_ch.physical_address),
   .rsp_page_flags       (rsp_ch.page_flags)
);

`default_nettype wire

@@ sim/reserved_region_translator_test.sv @@
// ----------------------------------------------------------------------------
// reserved_region_translator_test
// Drives region writes and address translations into the translator, keeps a
// shadow region table to predict every response beat, and checks the beats
// field by field under random request idle cycles and response back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module reserved_region_translator_test;
   import rrt_pkg::*;

   localparam int SLOTS = REGION_SLOTS_DEF;
   localparam logic [RTYPE_W-1:0] RTYPE_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0]  ALL_ONES     = {ADDR_W{1'b1}};

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [ADDR_W-1:0]  base;
      logic [PAGES_W-1:0] pages;
      logic [ADDR_W-1:0]  backing;
      logic [RTYPE_W-1:0] rtype;
      logic [ADDR_W-1:0]  vaddr;
   } region_req_type;

   typedef struct packed {
      logic               hit;
      logic [ADDR_W-1:0]  phys;
      logic [FLAGS_W-1:0] flags;
   } xlate_result_type;

   class region_scoreboard;
      logic [COUNT_W-1:0] region_count;
      logic [ADDR_W-1:0]  entry_address;
      rrt_entry_type      slots [SLOTS];
      xlate_result_type   pending_results [$];
      int                 errors;

      function new();
         region_count  = '0;
         entry_address = '0;
         foreach (slots[i]) slots[i] = '0;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_REGION_COUNT) begin
            region_count = value[COUNT_W-1:0];
         end else if (idx == CSR_ENTRY_ADDRESS) begin
            entry_address = value;
         end
      endfunction

      function xlate_result_type translate(logic [ADDR_W-1:0] va);
         xlate_result_type  res;
         int                limit;
         logic [ADDR_W-1:0] span;
         logic [ADDR_W-1:0] stop;
         res = '0;
         if (va[PAGE_OFS_W-1:0] != '0) begin
            return res;
         end
         limit = (region_count > SLOTS) ? SLOTS : int'(region_count);
         for (int i = 0; i < limit; i++) begin
            span = {20'h0, slots[i].pages, 12'h0};
            stop = slots[i].base + span;
            // skip empty, wrapping or unbacked regions
            if (span == '0 || stop <= slots[i].base) continue;
            if (va < slots[i].base || va >= stop || slots[i].backing == '0) continue;
            res.hit   = 1'b1;
            res.phys  = slots[i].backing + (va - slots[i].base);
            res.flags = FLAG_PRESENT | FLAG_USER;
            if (slots[i].rtype == RTYPE_IMAGE) begin
               if (entry_address == '0 || va != {entry_address[ADDR_W-1:PAGE_OFS_W], 12'h0})
                  res.flags = res.flags | FLAG_NX;
            end else if (slots[i].rtype == RTYPE_STACK) begin
               res.flags = res.flags | FLAG_WRITABLE | FLAG_NX;
            end else begin
               res.flags = res.flags | FLAG_NX;
            end
            return res;
         end
         return res;
      endfunction

      function void note_request(region_req_type r);
         if (r.kind == KIND_WRITE) begin
            if (r.slot < SLOTS) begin
               slots[r.slot].base    = r.base;
               slots[r.slot].pages   = r.pages;
               slots[r.slot].backing = r.backing;
               slots[r.slot].rtype   = r.rtype;
            end
            pending_results.push_back('0);
         end else begin
            pending_results.push_back(translate(r.vaddr));
         end
      endfunction

      function void check_response(xlate_result_type got);
         xlate_result_type want;
         if (pending_results.size() == 0) begin
            $error("response beat with nothing expected: hit %0b pa %h flags %h",
                   got.hit, got.phys, got.flags);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0b actual %0b", want.hit, got.hit);
            errors++;
         end
         if (got.phys !== want.phys) begin
            $error("physical_address: expected %h actual %h", want.phys, got.phys);
            errors++;
         end
         if (got.flags !== want.flags) begin
            $error("page_flags: expected %h actual %h", want.flags, got.flags);
            errors++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_enabled;

   rrt_req_if req_bus ();
   rrt_rsp_if rsp_bus ();
   rrt_csr_if csr_bus ();

   region_scoreboard sb = new();

   reserved_region_translator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = !(idle_enabled && $urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_response('{hit: rsp_bus.hit, phys: rsp_bus.physical_address,
                             flags: rsp_bus.page_flags});
      end
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic region_req_type slot_write(logic [SLOT_W-1:0] slot,
                                                 logic [ADDR_W-1:0] base,
                                                 logic [PAGES_W-1:0] pages,
                                                 logic [ADDR_W-1:0] backing,
                                                 logic [RTYPE_W-1:0] rtype);
      region_req_type r;
      r = '0;
      r.kind    = KIND_WRITE;
      r.slot    = slot;
      r.base    = base;
      r.pages   = pages;
      r.backing = backing;
      r.rtype   = rtype;
      return r;
   endfunction

   function automatic region_req_type lookup(logic [ADDR_W-1:0] va);
      region_req_type r;
      r = '0;
      r.kind  = KIND_XLATE;
      r.vaddr = va;
      return r;
   endfunction

   function automatic region_req_type make_random_item();
      region_req_type r;
      rrt_entry_type  s;
      int unsigned    pick;
      int unsigned    pg_lim;
      r.slot    = SLOT_W'($urandom);
      r.base    = rand64();
      r.pages   = $urandom;
      r.backing = rand64();
      r.rtype   = RTYPE_W'($urandom);
      r.vaddr   = rand64();
      pick = $urandom_range(99);
      if ($urandom_range(99) < 25) begin
         r.kind = KIND_WRITE;
         if (pick < 60) r.base[PAGE_OFS_W-1:0] = '0;
         else if (pick < 70) r.base = {ALL_ONES[ADDR_W-1:PAGE_OFS_W], 12'h0}
                                      - (64'($urandom_range(0, 8)) << 12);
         else if (pick < 80) r.base = {44'($urandom_range(0, 255)), 20'h0};
         pick = $urandom_range(99);
         if (pick < 70) r.pages = $urandom_range(1, 16);
         else if (pick < 80) r.pages = '0;
         else if (pick < 90) r.pages = $urandom_range(1, 1 << 20);
         if ($urandom_range(99) < 10) r.backing = '0;
      end else begin
         r.kind = KIND_XLATE;
         s = sb.slots[$urandom_range(SLOTS - 1)];
         pg_lim = (s.pages > 64) ? 63 : ((s.pages == 0) ? 0 : s.pages - 1);
         if (pick < 45) r.vaddr = s.base + (64'($urandom_range(0, pg_lim)) << 12);
         else if (pick < 55) r.vaddr = s.base + (64'(s.pages) << 12);
         else if (pick < 65) r.vaddr = s.base + 64'($urandom_range(1, 4095));
         else if (pick < 77) r.vaddr = {sb.entry_address[ADDR_W-1:PAGE_OFS_W], 12'h0};
         else if (pick < 88) r.vaddr[PAGE_OFS_W-1:0] = '0;
      end
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_request(region_req_type r);
      while (idle_enabled && $urandom_range(99) < 32) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.kind            = r.kind;
      req_bus.region_slot     = r.slot;
      req_bus.region_base     = r.base;
      req_bus.region_pages    = r.pages;
      req_bus.region_backing  = r.backing;
      req_bus.region_type     = r.rtype;
      req_bus.virtual_address = r.vaddr;
      req_bus.valid           = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(r);
      @(negedge clock);
   endtask

   // drop valid and hold until every response has come back
   task automatic settle();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure_random();
      logic [CSR_DATA_W-1:0] count_val;
      logic [CSR_DATA_W-1:0] entry_val;
      int unsigned           pick;
      rrt_entry_type         s;
      pick = $urandom_range(99);
      if (pick < 55) count_val = CSR_DATA_W'(SLOTS);
      else if (pick < 75) count_val = CSR_DATA_W'($urandom_range(1, SLOTS - 1));
      else if (pick < 88) count_val = CSR_DATA_W'($urandom_range(SLOTS + 1, 15));
      else count_val = '0;
      pick = $urandom_range(99);
      s = sb.slots[$urandom_range(SLOTS - 1)];
      // aim the entry point into the first four pages of a random slot's region in 40 of 100 picks
      if (pick < 40) entry_val = s.base + (64'($urandom_range(0, 3)) << 12)
                                 + 64'($urandom_range(0, 4095));
      else if (pick < 55) entry_val = '0;
      else if (pick < 62) entry_val = ALL_ONES;
      else entry_val = rand64();
      write_register(CSR_REGION_COUNT, count_val);
      write_register(CSR_ENTRY_ADDRESS, entry_val);
   endtask

   initial begin
      reset           = 1'b1;
      idle_enabled    = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.kind    = KIND_WRITE;
      req_bus.region_slot     = '0;
      req_bus.region_base     = '0;
      req_bus.region_pages    = '0;
      req_bus.region_backing  = '0;
      req_bus.region_type     = RTYPE_IMAGE;
      req_bus.virtual_address = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_REGION_COUNT;
      csr_bus.data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty search straight out of reset
      send_request(lookup(64'h0));
      settle();
      write_register(CSR_REGION_COUNT, CSR_DATA_W'(SLOTS));
      write_register(CSR_ENTRY_ADDRESS, 64'h0000_0000_1000_2345);

      send_request(slot_write(3'd0, 64'h1000_0000, 32'd4, 64'h8000_0000, RTYPE_IMAGE));
      // end wraps past the top: skipped
      send_request(slot_write(3'd1, 64'hFFFF_FFFF_FFFF_E000, 32'd2, 64'h1234_5000,
                              RTYPE_STACK));
      send_request(slot_write(3'd2, 64'hFFFF_FFFF_FFFF_E000, 32'd1, ALL_ONES << 12,
                              RTYPE_STACK));
      send_request(slot_write(3'd3, 64'h2000, 32'hFFFF_FFFF, ALL_ONES << 12, RTYPE_UNUSED));
      send_request(slot_write(3'd4, 64'h4000_0000, 32'd0, 64'h1000, RTYPE_OTHER));
      send_request(slot_write(3'd5, 64'h5000_0000, 32'd8, 64'h0, RTYPE_OTHER));
      send_request(slot_write(3'd7, 64'h0, 32'hFFFF_FFFF, ALL_ONES, RTYPE_OTHER));
      send_request(lookup(64'h1000_2000));
      send_request(lookup(64'h1000_0000));
      send_request(lookup(64'h1000_3000));
      send_request(lookup(64'h1000_4000));
      send_request(lookup(64'h1000_0001));
      send_request(lookup(64'hFFFF_FFFF_FFFF_E000));
      send_request(lookup(64'hFFFF_FFFF_FFFF_F000));
      send_request(lookup(64'h3000));
      send_request(lookup(64'h0));
      send_request(lookup(64'h4000_0000));
      send_request(lookup(64'h5000_0000));
      send_request(lookup(ALL_ONES));
      settle();
      write_register(CSR_REGION_COUNT, 64'd15);
      send_request(lookup(64'h1000_2000));
      settle();
      write_register(CSR_REGION_COUNT, 64'd0);
      send_request(lookup(64'h1000_2000));
      settle();
      write_register(CSR_REGION_COUNT, 64'd1);
      write_register(CSR_ENTRY_ADDRESS, 64'h0);
      send_request(lookup(64'h1000_2000));
      settle();
      write_register(CSR_ENTRY_ADDRESS, ALL_ONES);

      for (int ph = 0; ph < 10; ph++) begin
         idle_enabled = !(ph == 3 || ph == 4);
         for (int k = 0; k < 93; k++) send_request(make_random_item());
         settle();
         configure_random();
      end
      idle_enabled = 1'b1;

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
